FILE: sv/ctu_pkg.sv
`default_nettype none

package ctu_pkg;

   localparam int PIXEL_W = 8;
   localparam int CODE_W = 8;
   localparam int POS_W = 10;
   localparam int CFG_W = 11;
   localparam int CSR_IDX_W = 1;

   localparam int DEFAULT_MAX_WIDTH = 1024;
   localparam int DEFAULT_MAX_HEIGHT = 1024;

   localparam logic [CFG_W-1:0] CFG_SIZE_RESET = 11'd1024;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   // A pixel's results; they leave as inner_left, inner_right, outer.
   typedef struct packed {
      logic outer;
      logic inner_right;
      logic inner_left;
      logic code_on;
   } emit_flags_type;

endpackage

`default_nettype wire

FILE: sv/ctu_req_if.sv
`default_nettype none

interface ctu_req_if
   import ctu_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [PIXEL_W-1:0] pixel;
   logic               frame_start;

   modport source (output valid, pixel, frame_start, input ready);
   modport sink (input valid, pixel, frame_start, output ready);
endinterface

`default_nettype wire

FILE: sv/ctu_rsp_if.sv
`default_nettype none

interface ctu_rsp_if
   import ctu_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [CODE_W-1:0] census_code;
   logic [POS_W-1:0]  out_col;
   logic [POS_W-1:0]  out_row;
   logic              last_of_item;

   modport source (output valid, census_code, out_col, out_row, last_of_item, input ready);
   modport sink (input valid, census_code, out_col, out_row, last_of_item, output ready);
endinterface

`default_nettype wire

FILE: sv/ctu_line_mem.sv
`default_nettype none

module ctu_line_mem
   import ctu_pkg::*;
#(
   parameter int DEPTH = DEFAULT_MAX_WIDTH,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic               clock,
   input  wire logic               rd_en,
   input  wire logic [AW-1:0]      rd_addr,
   output logic      [PIXEL_W-1:0] rd_data,
   input  wire logic               wr_en,
   input  wire logic [AW-1:0]      wr_addr,
   input  wire logic [PIXEL_W-1:0] wr_data
);

   logic [PIXEL_W-1:0] line_ff [DEPTH];
   logic [PIXEL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= line_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: sv/ctu_scan.sv
`default_nettype none

module ctu_scan
   import ctu_pkg::*;
#(
   parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEFAULT_MAX_HEIGHT,
   localparam int CW = $clog2(MAX_WIDTH),
   localparam int RW = $clog2(MAX_HEIGHT)
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CFG_W-1:0]     csr_wdata,
   input  wire logic                 accept,
   input  wire logic                 frame_start,
   output logic      [CW-1:0]        col,
   output logic      [RW-1:0]        row,
   output emit_flags_type            flags
);

   logic [CFG_W-1:0] frame_width_ff;
   logic [CFG_W-1:0] frame_height_ff;
   logic [CW-1:0]    col_count_ff;
   logic [CW-1:0]    col_count_in;
   logic [RW-1:0]    row_count_ff;
   logic [RW-1:0]    row_count_in;
   logic [CW-1:0]    w_last;
   logic [RW-1:0]    h_last;
   logic [CW-1:0]    col_base;
   logic [RW-1:0]    row_base;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff <= CFG_SIZE_RESET;
         frame_height_ff <= CFG_SIZE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH: frame_width_ff <= csr_wdata;
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (frame_width_ff == '0) begin
         w_last = '0;
      end else if (32'(frame_width_ff) > MAX_WIDTH) begin
         w_last = CW'(MAX_WIDTH - 1);
      end else begin
         w_last = CW'(frame_width_ff - 1'b1);
      end
      if (frame_height_ff == '0) begin
         h_last = '0;
      end else if (32'(frame_height_ff) > MAX_HEIGHT) begin
         h_last = RW'(MAX_HEIGHT - 1);
      end else begin
         h_last = RW'(frame_height_ff - 1'b1);
      end
   end

   always_comb begin
      col_base = frame_start ? '0 : col_count_ff;
      row_base = frame_start ? '0 : row_count_ff;
      col = (col_base > w_last) ? w_last : col_base;
      row = (row_base > h_last) ? h_last : row_base;

      flags.inner_left = (row >= RW'(2)) && (col >= CW'(1));
      flags.inner_right = (row >= RW'(2)) && (col == w_last);
      flags.outer = (row == '0) || (row == h_last);
      flags.code_on = (col >= CW'(2));

      if (col == w_last) begin
         col_count_in = '0;
         row_count_in = (row == h_last) ? '0 : row + 1'b1;
      end else begin
         col_count_in = col + 1'b1;
         row_count_in = row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_count_ff <= '0;
         row_count_ff <= '0;
      end else if (accept) begin
         col_count_ff <= col_count_in;
         row_count_ff <= row_count_in;
      end
   end

endmodule

`default_nettype wire

FILE: sv/ctu_emit.sv
`default_nettype none

module ctu_emit
   import ctu_pkg::*;
#(
   parameter int CW = 10,
   parameter int RW = 10
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               accept,
   output logic                    ready,
   input  wire logic [PIXEL_W-1:0] pixel,
   input  wire logic [CW-1:0]      col,
   input  wire logic [RW-1:0]      row,
   input  wire emit_flags_type     flags,
   input  wire logic [PIXEL_W-1:0] upper_rd,
   input  wire logic [PIXEL_W-1:0] middle_rd,
   output logic                    wr_en,
   output logic      [CW-1:0]      wr_addr,
   output logic      [PIXEL_W-1:0] upper_wdata,
   output logic      [PIXEL_W-1:0] middle_wdata,
   output logic                    out_valid,
   input  wire logic               out_ready,
   output logic      [CODE_W-1:0]  out_code,
   output logic      [POS_W-1:0]   out_col,
   output logic      [POS_W-1:0]   out_row,
   output logic                    out_last
);

   logic               s1_valid_ff;
   logic [PIXEL_W-1:0] s1_pixel_ff;
   logic [CW-1:0]      s1_col_ff;
   logic [RW-1:0]      s1_row_ff;
   logic [2:0]         s1_pend_ff;
   logic               s1_code_on_ff;
   logic               s1_fwd_ff;
   logic [PIXEL_W-1:0] win_ff [6];

   logic               out_valid_ff;
   logic [CODE_W-1:0]  out_code_ff;
   logic [POS_W-1:0]   out_col_ff;
   logic [POS_W-1:0]   out_row_ff;
   logic               out_last_ff;

   logic [PIXEL_W-1:0] u_eff;
   logic [PIXEL_W-1:0] m_eff;
   logic [PIXEL_W-1:0] ctr;
   logic [CODE_W-1:0]  code;
   logic [2:0]         low_bit;
   logic [2:0]         rest;
   logic               push;
   logic               retire;
   logic [CODE_W-1:0]  sel_code;
   logic [CW-1:0]      sel_col;
   logic [RW-1:0]      sel_row;
   logic               fwd_in;

   // The line stores still hold the old entry when the next pixel reads the
   // column that the retiring pixel writes; the window then has the new data.
   always_comb begin
      u_eff = s1_fwd_ff ? win_ff[1] : upper_rd;
      m_eff = s1_fwd_ff ? win_ff[2] : middle_rd;
      ctr = win_ff[1];
      code[7] = win_ff[3] > ctr;
      code[6] = win_ff[0] > ctr;
      code[5] = u_eff > ctr;
      code[4] = m_eff > ctr;
      code[3] = s1_pixel_ff > ctr;
      code[2] = win_ff[2] > ctr;
      code[1] = win_ff[5] > ctr;
      code[0] = win_ff[4] > ctr;

      low_bit = s1_pend_ff & (~s1_pend_ff + 3'd1);
      rest = s1_pend_ff & ~low_bit;
      push = s1_valid_ff && (s1_pend_ff != '0) && (!out_valid_ff || out_ready);
      retire = s1_valid_ff && ((s1_pend_ff == '0) || (push && (rest == '0)));
      ready = !s1_valid_ff || retire;
      fwd_in = retire && (col == s1_col_ff);

      sel_code = '0;
      sel_col = s1_col_ff;
      sel_row = s1_row_ff;
      if (s1_pend_ff[0]) begin
         sel_code = s1_code_on_ff ? code : '0;
         sel_col = s1_col_ff - 1'b1;
         sel_row = s1_row_ff - 1'b1;
      end else if (s1_pend_ff[1]) begin
         sel_row = s1_row_ff - 1'b1;
      end

      wr_en = retire;
      wr_addr = s1_col_ff;
      upper_wdata = m_eff;
      middle_wdata = s1_pixel_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s1_pend_ff <= '0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
         s1_pend_ff <= {flags.outer, flags.inner_right, flags.inner_left};
      end else if (retire) begin
         s1_valid_ff <= 1'b0;
         s1_pend_ff <= '0;
      end else if (push) begin
         s1_pend_ff <= rest;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pixel_ff <= pixel;
         s1_col_ff <= col;
         s1_row_ff <= row;
         s1_code_on_ff <= flags.code_on;
         s1_fwd_ff <= fwd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else if (retire) begin
         win_ff[3] <= win_ff[0];
         win_ff[4] <= win_ff[1];
         win_ff[5] <= win_ff[2];
         win_ff[0] <= u_eff;
         win_ff[1] <= m_eff;
         win_ff[2] <= s1_pixel_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (push) begin
         out_valid_ff <= 1'b1;
      end else if (out_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         out_code_ff <= sel_code;
         out_col_ff <= POS_W'(sel_col);
         out_row_ff <= POS_W'(sel_row);
         out_last_ff <= (rest == '0);
      end
   end

   assign out_valid = out_valid_ff;
   assign out_code = out_code_ff;
   assign out_col = out_col_ff;
   assign out_row = out_row_ff;
   assign out_last = out_last_ff;

endmodule

`default_nettype wire

FILE: sv/census_transform_3x3_unit.sv
// Channel   Direction  Payload                                          Handshake
// req_ch    in         pixel[7:0], frame_start                          valid/ready
// rsp_ch    out        census_code[7:0], out_col[9:0], out_row[9:0],    valid/ready
//                      last_of_item
// csr       in         csr_we, csr_index[0:0], csr_wdata[10:0]          write enable
//
// A pixel is taken in once the one before has put its last word into the output
// register, so output stalls can hold the input; the last row of the frame sends up
// to three words for one pixel. The line stores are read into registers as a pixel is taken in.
// Reset is synchronous, clears the counters and the window, and sets both size
// registers to 1024.
// A stalled output register holds its word while the next pixel is taken in.
`default_nettype none

module census_transform_3x3_unit
   import ctu_pkg::*;
#(
   parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEFAULT_MAX_HEIGHT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   ctu_req_if.sink                   req_ch,
   ctu_rsp_if.source                 rsp_ch,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CFG_W-1:0]     csr_wdata
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);

   logic               accept;
   logic               ready;
   logic [CW-1:0]      col;
   logic [RW-1:0]      row;
   emit_flags_type     flags;
   logic [PIXEL_W-1:0] upper_rd;
   logic [PIXEL_W-1:0] middle_rd;
   logic               wr_en;
   logic [CW-1:0]      wr_addr;
   logic [PIXEL_W-1:0] upper_wdata;
   logic [PIXEL_W-1:0] middle_wdata;

   assign accept = req_ch.valid && ready;
   assign req_ch.ready = ready;

   ctu_scan #(
      .MAX_WIDTH(MAX_WIDTH),
      .MAX_HEIGHT(MAX_HEIGHT)
   ) u_scan (
      .clock(clock),
      .reset(reset),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .accept(accept),
      .frame_start(req_ch.frame_start),
      .col(col),
      .row(row),
      .flags(flags)
   );

   ctu_line_mem #(
      .DEPTH(MAX_WIDTH)
   ) u_upper_mem (
      .clock(clock),
      .rd_en(accept),
      .rd_addr(col),
      .rd_data(upper_rd),
      .wr_en(wr_en),
      .wr_addr(wr_addr),
      .wr_data(upper_wdata)
   );

   ctu_line_mem #(
      .DEPTH(MAX_WIDTH)
   ) u_middle_mem (
      .clock(clock),
      .rd_en(accept),
      .rd_addr(col),
      .rd_data(middle_rd),
      .wr_en(wr_en),
      .wr_addr(wr_addr),
      .wr_data(middle_wdata)
   );

   ctu_emit #(
      .CW(CW),
      .RW(RW)
   ) u_emit (
      .clock(clock),
      .reset(reset),
      .accept(accept),
      .ready(ready),
      .pixel(req_ch.pixel),
      .col(col),
      .row(row),
      .flags(flags),
      .upper_rd(upper_rd),
      .middle_rd(middle_rd),
      .wr_en(wr_en),
      .wr_addr(wr_addr),
      .upper_wdata(upper_wdata),
      .middle_wdata(middle_wdata),
      .out_valid(rsp_ch.valid),
      .out_ready(rsp_ch.ready),
      .out_code(rsp_ch.census_code),
      .out_col(rsp_ch.out_col),
      .out_row(rsp_ch.out_row),
      .out_last(rsp_ch.last_of_item)
   );

endmodule

`default_nettype wire

FILE: sv/ctu_checker.sv
`default_nettype none

module ctu_checker
   import ctu_pkg::*;
(
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire logic [CODE_W-1:0] rsp_code,
   input wire logic [POS_W-1:0]  rsp_col,
   input wire logic [POS_W-1:0]  rsp_row,
   input wire logic              rsp_last
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("Result word dropped while stalled.");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable({rsp_code, rsp_col, rsp_row, rsp_last}))
      else $error("Result word changed while stalled.");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("Result word shown right after reset.");

   a_burst_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> rsp_valid)
      else $error("Words of one pixel did not follow each other.");

endmodule

bind census_transform_3x3_unit ctu_checker u_ctu_checker (
   .clock(clock),
   .reset(reset),
   .rsp_valid(rsp_ch.valid),
   .rsp_ready(rsp_ch.ready),
   .rsp_code(rsp_ch.census_code),
   .rsp_col(rsp_ch.out_col),
   .rsp_row(rsp_ch.out_row),
   .rsp_last(rsp_ch.last_of_item)
);

`default_nettype wire

FILE: dv/tb_census_transform_3x3_unit.sv
`default_nettype none

module tb_census_transform_3x3_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import ctu_pkg::*;

   typedef struct packed {
      logic [CODE_W-1:0] census_code;
      logic [POS_W-1:0]  out_col;
      logic [POS_W-1:0]  out_row;
      logic              last_of_item;
   } census_word_type;

   logic                 clock;
   logic                 reset;
   logic                 csr_we;
   csr_index_type        csr_index;
   logic [CFG_W-1:0]     csr_wdata;

   ctu_req_if req_ch ();
   ctu_rsp_if rsp_ch ();

   census_transform_3x3_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Predicted state of the block.
   logic [PIXEL_W-1:0] upper_store [DEFAULT_MAX_WIDTH];
   logic [PIXEL_W-1:0] middle_store [DEFAULT_MAX_WIDTH];
   logic [PIXEL_W-1:0] census_window [6];
   int unsigned        col_pos;
   int unsigned        row_pos;
   logic [CFG_W-1:0]   width_cfg;
   logic [CFG_W-1:0]   height_cfg;

   census_word_type census_due [$];
   int              failures = 0;
   bit              send_steady = 1'b0;
   bit              take_steady = 1'b0;

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   function automatic int unsigned used_size(input logic [CFG_W-1:0] v, input int unsigned maxv);
      if (v == 0) return 1;
      if (v > maxv) return maxv;
      return v;
   endfunction

   task automatic census_predict(input logic [PIXEL_W-1:0] pix, input logic first);
      int unsigned        w;
      int unsigned        h;
      int unsigned        c;
      int unsigned        r;
      logic [PIXEL_W-1:0] u;
      logic [PIXEL_W-1:0] m;
      logic [PIXEL_W-1:0] ctr;
      logic [CODE_W-1:0]  code;
      census_word_type    words [$];
      w = used_size(width_cfg, DEFAULT_MAX_WIDTH);
      h = used_size(height_cfg, DEFAULT_MAX_HEIGHT);
      if (first) begin
         col_pos = 0;
         row_pos = 0;
      end
      c = (col_pos < w - 1) ? col_pos : w - 1;
      r = (row_pos < h - 1) ? row_pos : h - 1;
      u = upper_store[c];
      m = middle_store[c];
      ctr = census_window[1];
      code = {census_window[3] > ctr, census_window[0] > ctr, u > ctr, m > ctr,
              pix > ctr, census_window[2] > ctr, census_window[5] > ctr,
              census_window[4] > ctr};
      if (r >= 2) begin
         if (c >= 1) begin
            words.push_back('{census_code: (c >= 2) ? code : '0, out_col: POS_W'(c - 1),
                              out_row: POS_W'(r - 1), last_of_item: 1'b0});
         end
         if (c == w - 1) begin
            words.push_back('{census_code: '0, out_col: POS_W'(c),
                              out_row: POS_W'(r - 1), last_of_item: 1'b0});
         end
      end
      if (r == 0 || r == h - 1) begin
         words.push_back('{census_code: '0, out_col: POS_W'(c),
                           out_row: POS_W'(r), last_of_item: 1'b0});
      end
      if (words.size() > 0) words[words.size() - 1].last_of_item = 1'b1;
      foreach (words[k]) census_due.push_back(words[k]);
      census_window[3] = census_window[0];
      census_window[4] = census_window[1];
      census_window[5] = census_window[2];
      census_window[0] = u;
      census_window[1] = m;
      census_window[2] = pix;
      upper_store[c] = m;
      middle_store[c] = pix;
      if (c == w - 1) begin
         col_pos = 0;
         row_pos = (r == h - 1) ? 0 : r + 1;
      end else begin
         col_pos = c + 1;
         row_pos = r;
      end
   endtask

   task automatic send_pixel(input logic [PIXEL_W-1:0] pix, input logic first);
      int gap;
      gap = send_steady ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.pixel <= pix;
      req_ch.frame_start <= first;
      do @(posedge clock); while (!req_ch.ready);
      census_predict(pix, first);
   endtask

   // Stops the input and waits until every predicted word has come out, then waits on
   // to let pixels that are still in flight without causing a word pass.
   task automatic settle();
      req_ch.valid <= 1'b0;
      while (census_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic configure(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
      csr_we <= 1'b1;
      csr_index <= CSR_FRAME_WIDTH;
      csr_wdata <= w;
      @(posedge clock);
      width_cfg = w;
      csr_index <= CSR_FRAME_HEIGHT;
      csr_wdata <= h;
      @(posedge clock);
      height_cfg = h;
      csr_we <= 1'b0;
   endtask

   task automatic test_reset_sizes();
      send_pixel(8'd0, 1'b1);
      send_pixel(8'd255, 1'b0);
      send_pixel(8'd17, 1'b0);
      send_pixel(8'd255, 1'b0);
      send_pixel(8'd0, 1'b0);
   endtask

   task automatic test_patterns();
      logic [16*8-1:0] pat;
      pat = {8'd255, 8'd128, 8'd255, 8'd0,   8'd128, 8'd128, 8'd128, 8'd128,
             8'd128, 8'd255, 8'd0,   8'd255, 8'd10,  8'd255, 8'd255, 8'd200};
      settle();
      configure(11'd4, 11'd4);
      for (int i = 0; i < 16; i++) send_pixel(pat[8*i +: 8], i == 0);
      settle();
      configure(11'd3, 11'd3);
      for (int i = 0; i < 9; i++) send_pixel((i == 4) ? 8'd0 : 8'd255, i == 0);
      for (int i = 0; i < 9; i++) send_pixel((i == 4) ? 8'd255 : 8'd0, 1'b0);
   endtask

   task automatic test_smallest_sizes();
      settle();
      configure(11'd0, 11'd0);
      send_pixel(8'd1, 1'b1);
      send_pixel(8'd254, 1'b0);
      send_pixel(8'd3, 1'b1);
      settle();
      configure(11'd2, 11'd2);
      for (int i = 0; i < 6; i++) send_pixel(8'(i * 51), i == 0 || i == 4);
   endtask

   task automatic test_mid_frame_resize();
      settle();
      configure(11'd5, 11'd4);
      for (int i = 0; i < 14; i++) send_pixel(8'($urandom_range(0, 255)), i == 0);
      settle();
      configure(11'd3, 11'd4);
      send_pixel(8'd90, 1'b0);
      send_pixel(8'd91, 1'b0);
      settle();
      configure(11'd3, 11'd2);
      send_pixel(8'd200, 1'b0);
      send_pixel(8'd7, 1'b0);
   endtask

   task automatic test_size_limits();
      settle();
      configure(11'd2047, 11'd1);
      send_steady = 1'b1;
      for (int i = 0; i < 16; i++) send_pixel(8'($urandom_range(0, 255)), i == 0);
      settle();
      configure(11'd0, 11'd2047);
      send_steady = 1'b0;
      for (int i = 0; i < 16; i++) send_pixel(8'($urandom_range(0, 255)), i == 0);
   endtask

   task automatic test_random_frames();
      int                 w;
      int                 h;
      int                 frames;
      int                 count;
      int                 total;
      logic               need_start;
      logic               first;
      logic [PIXEL_W-1:0] pix;
      logic [PIXEL_W-1:0] prev;
      total = 0;
      prev = '0;
      while (total < 100) begin
         w = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
         h = $urandom_range(1, 6);
         settle();
         configure((w == 1 && $urandom_range(0, 1)) ? 11'd0 : CFG_W'(w),
                   (h == 1 && $urandom_range(0, 1)) ? 11'd0 : CFG_W'(h));
         send_steady = ($urandom_range(0, 3) == 0);
         take_steady = ($urandom_range(0, 3) == 0);
         need_start = 1'b1;
         frames = $urandom_range(1, 3);
         repeat (frames) begin
            count = w * h;
            if (count > 1 && $urandom_range(0, 5) == 0) count = $urandom_range(1, count - 1);
            if (count != w * h) need_start = 1'b1;
            for (int i = 0; i < count; i++) begin
               case ($urandom_range(0, 7))
                  0: begin
                     pix = 8'd0;
                  end
                  1: begin
                     pix = 8'd255;
                  end
                  2: begin
                     pix = prev;
                  end
                  default: begin
                     pix = 8'($urandom_range(0, 255));
                  end
               endcase
               if (i == 0) begin
                  first = need_start | 1'($urandom_range(0, 1));
                  need_start = (count != w * h);
               end else begin
                  first = ($urandom_range(0, 39) == 0);
                  if (first) need_start = 1'b1;
               end
               send_pixel(pix, first);
               prev = pix;
               total++;
            end
         end
      end
   endtask

   always @(posedge clock) begin : word_check
      census_word_type got;
      census_word_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = '{census_code: rsp_ch.census_code, out_col: rsp_ch.out_col,
                 out_row: rsp_ch.out_row, last_of_item: rsp_ch.last_of_item};
         if (census_due.size() == 0) begin
            if (failures < 10) begin
               $display("Unexpected word: code %02h col %0d row %0d last %0b",
                        got.census_code, got.out_col, got.out_row, got.last_of_item);
            end
            failures++;
         end else begin
            want = census_due.pop_front();
            if (got.census_code !== want.census_code || got.out_col !== want.out_col ||
                got.out_row !== want.out_row || got.last_of_item !== want.last_of_item) begin
               if (failures < 10) begin
                  $display({"Mismatch: expected code %02h col %0d row %0d last %0b, ",
                            "got code %02h col %0d row %0d last %0b"},
                           want.census_code, want.out_col, want.out_row, want.last_of_item,
                           got.census_code, got.out_col, got.out_row, got.last_of_item);
               end
               failures++;
            end
         end
      end
   end

   initial begin : word_sink
      int stall;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = take_steady ? 0 : $urandom_range(0, 15);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   initial begin
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.pixel <= '0;
      req_ch.frame_start <= 1'b0;
      csr_we <= 1'b0;
      csr_index <= CSR_FRAME_WIDTH;
      csr_wdata <= '0;
      foreach (upper_store[i]) upper_store[i] = '0;
      foreach (middle_store[i]) middle_store[i] = '0;
      foreach (census_window[i]) census_window[i] = '0;
      col_pos = 0;
      row_pos = 0;
      width_cfg = CFG_SIZE_RESET;
      height_cfg = CFG_SIZE_RESET;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_sizes();
      test_patterns();
      test_smallest_sizes();
      test_mid_frame_resize();
      test_size_limits();
      test_random_frames();
      settle();
      repeat (4) @(posedge clock);
      if (failures == 0 && census_due.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #15_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

`default_nettype wire

FILE: census_transform_3x3_unit.f
sv/ctu_pkg.sv
sv/ctu_req_if.sv
sv/ctu_rsp_if.sv
sv/ctu_line_mem.sv
sv/ctu_scan.sv
sv/ctu_emit.sv
sv/census_transform_3x3_unit.sv
sv/ctu_checker.sv
dv/tb_census_transform_3x3_unit.sv
